[rtl/mce_pkg.sv]
// Shared types, letter table and microcode program of the Morse encoder.
package mce_pkg;

    typedef logic [2:0] t_step;

    localparam t_step ST_IDLE  = 3'd0;
    localparam t_step ST_SYM   = 3'd1;
    localparam t_step ST_GAP   = 3'd2;
    localparam t_step ST_END   = 3'd3;
    localparam t_step ST_SPACE = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [15:0] UNIT_TICKS_RST = 16'd11025;

    localparam int unsigned TICKS_W = 19;

    typedef enum logic [1:0] {
        US_ONE    = 2'd0,
        US_THREE  = 2'd1,
        US_SEVEN  = 2'd2,
        US_SYMBOL = 2'd3
    } t_units_sel;

    typedef enum logic [1:0] {
        JC_NEXT   = 2'd0,
        JC_DECODE = 2'd1,
        JC_MORE   = 2'd2,
        JC_HOLD   = 2'd3
    } t_jump;

    // One control word per microcode step
    typedef struct packed {
        logic       accept;
        logic       emit;
        logic       silent;
        t_units_sel units;
        logic       last;
        logic       shift;
        t_jump      jump;
        t_step      next;
        t_step      alt;
    } t_cw;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic is_space;
        logic is_letter;
        logic more;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [2:0] count;
        logic [3:0] dashes;
    } t_glyph;

    // Symbols are read from bit count-1 downwards; a 1 is a dash.
    function automatic t_glyph glyph_lookup(input logic [4:0] idx);
        t_glyph g;
        case (idx)
            5'd0:    g = '{3'd2, 4'h1};
            5'd1:    g = '{3'd4, 4'h8};
            5'd2:    g = '{3'd4, 4'hA};
            5'd3:    g = '{3'd3, 4'h4};
            5'd4:    g = '{3'd1, 4'h0};
            5'd5:    g = '{3'd4, 4'h2};
            5'd6:    g = '{3'd3, 4'h6};
            5'd7:    g = '{3'd4, 4'h0};
            5'd8:    g = '{3'd2, 4'h0};
            5'd9:    g = '{3'd4, 4'h7};
            5'd10:   g = '{3'd3, 4'h5};
            5'd11:   g = '{3'd4, 4'h4};
            5'd12:   g = '{3'd2, 4'h3};
            5'd13:   g = '{3'd2, 4'h2};
            5'd14:   g = '{3'd3, 4'h7};
            5'd15:   g = '{3'd4, 4'h6};
            5'd16:   g = '{3'd4, 4'hD};
            5'd17:   g = '{3'd3, 4'h2};
            5'd18:   g = '{3'd3, 4'h0};
            5'd19:   g = '{3'd1, 4'h1};
            5'd20:   g = '{3'd3, 4'h1};
            5'd21:   g = '{3'd4, 4'h1};
            5'd22:   g = '{3'd3, 4'h3};
            5'd23:   g = '{3'd4, 4'h9};
            5'd24:   g = '{3'd4, 4'hB};
            5'd25:   g = '{3'd4, 4'hC};
            default: g = '{3'd1, 4'h0};
        endcase
        return g;
    endfunction

    // Control store
    function automatic t_cw ucode(input t_step step);
        t_cw cw;
        case (step)
            ST_IDLE:  cw = '{1'b1, 1'b0, 1'b0, US_ONE,    1'b0, 1'b0, JC_DECODE,
                             ST_SYM,  ST_SPACE};
            ST_SYM:   cw = '{1'b0, 1'b1, 1'b0, US_SYMBOL, 1'b0, 1'b1, JC_MORE,
                             ST_GAP,  ST_END};
            ST_GAP:   cw = '{1'b0, 1'b1, 1'b1, US_ONE,    1'b0, 1'b0, JC_NEXT,
                             ST_SYM,  ST_SYM};
            ST_END:   cw = '{1'b0, 1'b1, 1'b1, US_THREE,  1'b1, 1'b0, JC_NEXT,
                             ST_IDLE, ST_IDLE};
            ST_SPACE: cw = '{1'b0, 1'b1, 1'b1, US_SEVEN,  1'b1, 1'b0, JC_NEXT,
                             ST_IDLE, ST_IDLE};
            default:  cw = '{1'b0, 1'b0, 1'b0, US_ONE,    1'b0, 1'b0, JC_NEXT,
                             ST_IDLE, ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage

[rtl/mce_seq.sv]
// Microcode sequencer: step counter, control store read and jump logic.
module mce_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mce_pkg::t_dp_status    i_status,
    output mce_pkg::t_cw           o_cw
);
    import mce_pkg::*;

    t_step r_step;
    t_step n_step;
    t_cw   cw;

    assign cw   = ucode(r_step);
    assign o_cw = cw;

    always_comb begin
        n_step = r_step;
        if (!(cw.emit && !i_status.out_free)) begin
            case (cw.jump)
                JC_NEXT: begin
                    n_step = cw.next;
                end
                JC_DECODE: begin
                    if (i_status.in_valid && i_status.is_space) begin
                        n_step = cw.alt;
                    end else if (i_status.in_valid && i_status.is_letter) begin
                        n_step = cw.next;
                    end
                end
                JC_MORE: begin
                    n_step = i_status.more ? cw.next : cw.alt;
                end
                default: begin
                    n_step = r_step;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[rtl/mce_datapath.sv]
// Datapath: character decode, glyph registers, tick product and output register.
module mce_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mce_pkg::t_cw           i_cw,
    input  logic                   i_in_valid,
    input  logic [7:0]             i_char,
    input  logic [15:0]            i_unit_ticks,
    input  logic                   i_out_ready,
    output mce_pkg::t_dp_status    o_status,
    output logic                   o_out_valid,
    output logic                   o_is_silent,
    output logic [2:0]             o_length_units,
    output logic [mce_pkg::TICKS_W-1:0] o_length_ticks,
    output logic                   o_last
);
    import mce_pkg::*;

    logic       is_upper;
    logic [7:0] folded;
    logic       is_letter;
    logic       is_space;
    logic       out_free;
    logic       emit_go;
    logic       load;
    logic [1:0] sym_idx;
    logic       cur_dash;
    logic [2:0] units;
    t_glyph     glyph;

    logic [2:0] r_count;
    logic [3:0] r_dashes;
    logic       r_out_valid;
    logic       r_silent;
    logic [2:0] r_units;
    logic [TICKS_W-1:0] r_ticks;
    logic       r_last;

    assign is_upper  = (i_char >= CH_UC_A) && (i_char <= CH_UC_Z);
    assign folded    = is_upper ? (i_char | CASE_BIT) : i_char;
    assign is_letter = (folded >= CH_LC_A) && (folded <= CH_LC_Z);
    assign is_space  = (i_char == CH_SPACE);
    assign glyph     = glyph_lookup(5'(folded - CH_LC_A));

    assign out_free = !r_out_valid || i_out_ready;
    assign emit_go  = i_cw.emit && out_free;
    assign load     = i_cw.accept && i_in_valid && is_letter;

    // current symbol is the highest one not yet sent
    assign sym_idx  = 2'(r_count - 3'd1);
    assign cur_dash = r_dashes[sym_idx];

    always_comb begin
        case (i_cw.units)
            US_ONE:    units = 3'd1;
            US_THREE:  units = 3'd3;
            US_SEVEN:  units = 3'd7;
            US_SYMBOL: units = cur_dash ? 3'd3 : 3'd1;
            default:   units = 3'd1;
        endcase
    end

    assign o_status.in_valid  = i_in_valid;
    assign o_status.is_space  = is_space;
    assign o_status.is_letter = is_letter;
    assign o_status.more      = (r_count > 3'd1);
    assign o_status.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_count  <= glyph.count;
            r_dashes <= glyph.dashes;
        end else if (emit_go && i_cw.shift) begin
            r_count  <= r_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_silent <= i_cw.silent;
            r_units  <= units;
            r_ticks  <= TICKS_W'(units) * TICKS_W'(i_unit_ticks);
            r_last   <= i_cw.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_silent    = r_silent;
    assign o_length_units = r_units;
    assign o_length_ticks = r_ticks;
    assign o_last         = r_last;

endmodule

[rtl/morse_character_encoder.sv]
// Top level of the Morse character encoder: register port, sequencer and datapath.
// One character item goes in on the s_axis side; each keying element comes out
// on the m_axis side, with tuser high for a silence and tlast on the final element
// of the character. The sequencer takes the character in its idle step and then
// moves through one step per element; a letter gives a tone for each symbol and a
// silence after each, a space gives a single silence and any other code is dropped.
// A stalled output holds the sequencer in place. unit_ticks sits at address 0 and
// resets to 11025.
module morse_character_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // character items in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    // keying elements out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] length_units, [21:3] length_ticks,
                                        // [23:22] zero
    output logic        m_axis_tuser,   // [0] is_silent
    output logic        m_axis_tlast
);
    import mce_pkg::*;

    logic [15:0]  r_unit_ticks;
    logic         cfg_wr;
    t_cw          cw;
    t_dp_status   status;
    logic         is_silent;
    logic [2:0]   length_units;
    logic [TICKS_W-1:0] length_ticks;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RST;
        end else if (cfg_wr) begin
            r_unit_ticks <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_unit_ticks};

    mce_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cw     (cw)
    );

    mce_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cw           (cw),
        .i_in_valid     (s_axis_tvalid),
        .i_char         (s_axis_tdata),
        .i_unit_ticks   (r_unit_ticks),
        .i_out_ready    (m_axis_tready),
        .o_status       (status),
        .o_out_valid    (m_axis_tvalid),
        .o_is_silent    (is_silent),
        .o_length_units (length_units),
        .o_length_ticks (length_ticks),
        .o_last         (m_axis_tlast)
    );

    assign s_axis_tready = cw.accept;
    assign m_axis_tdata  = {2'b00, length_ticks, length_units};
    assign m_axis_tuser  = is_silent;

    // tone elements are only dots or dashes
    a_tone_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[2:0] == 3'd1 || m_axis_tdata[2:0] == 3'd3))
        else $error("tone element with bad length");

    // a character always ends on a silence
    a_last_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("final element is not a silence");

    // after a letter is taken the sequencer is busy sending it
    a_letter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && status.is_letter) |=> !s_axis_tready)
        else $error("new item taken straight after a letter");

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the Morse character encoder: stimulus, pacing and element scoreboard.
module tb_top;
    import mce_pkg::*;

    localparam logic [2:0] REG_UNIT_TICKS = 3'd0;
    localparam logic [2:0] REG_UNUSED     = 3'd4;
    localparam int         NUM_PHASES     = 5;
    localparam int         PHASE_ITEMS    = 30;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         HOLD_CYCLES    = 300;

    typedef struct packed {
        logic        silent;
        logic [2:0]  units;
        logic [18:0] ticks;
        logic        last;
    } t_element;

    // Keeps the keying elements still owed by the block, oldest first.
    class morse_scoreboard;
        t_element    owed[$];
        logic [15:0] unit_ticks;
        string       code_of[26];
        int          errors;
        int          chars_taken;
        int          elems_checked;

        function new();
            unit_ticks = UNIT_TICKS_RST;
            code_of = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
            errors = 0;
            chars_taken = 0;
            elems_checked = 0;
        endfunction

        function void mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void owe(logic silent, int units, logic last);
            t_element    e;
            logic [31:0] prod;
            prod = units * unit_ticks;
            e.silent = silent;
            e.units  = units[2:0];
            e.ticks  = prod[18:0];
            e.last   = last;
            owed = {owed, e};
        endfunction

        // Expands one accepted character into the elements it should produce
        function void take_char(logic [7:0] code);
            logic [7:0] c;
            string      sym;
            int         i;
            c = code;
            chars_taken++;
            if (c == CH_SPACE) begin
                owe(1'b1, 7, 1'b1);
                return;
            end
            if (c >= CH_UC_A && c <= CH_UC_Z)
                c = c | CASE_BIT;
            if (c < CH_LC_A || c > CH_LC_Z)
                return;
            sym = code_of[c - CH_LC_A];
            for (i = 0; i < sym.len(); i++) begin
                owe(1'b0, (sym.getc(i) == "-") ? 3 : 1, 1'b0);
                if (i + 1 < sym.len())
                    owe(1'b1, 1, 1'b0);
            end
            owe(1'b1, 3, 1'b1);
        endfunction

        function void check_element(logic [23:0] data, logic usr, logic tl);
            t_element want;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected element, expected none, got data=%h user=%b last=%b",
                         $time, data, usr, tl);
                return;
            end
            want = owed.pop_front();
            elems_checked++;
            if (usr !== want.silent)
                mismatch("is_silent", 32'(want.silent), 32'(usr));
            if (data[2:0] !== want.units)
                mismatch("length_units", 32'(want.units), 32'(data[2:0]));
            if (data[21:3] !== want.ticks)
                mismatch("length_ticks", 32'(want.ticks), 32'(data[21:3]));
            if (data[23:22] !== 2'b00)
                mismatch("tdata pad bits", 32'd0, 32'(data[23:22]));
            if (tl !== want.last)
                mismatch("tlast", 32'(want.last), 32'(tl));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    morse_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit long_hold     = 1'b0;
    int held_cycles   = 0;

    morse_character_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [2:0] length_units, [21:3] length_ticks,
                                         // [23:22] zero
        .m_axis_tuser  (m_axis_tuser),   // [0] is_silent
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Output side pacing; a long hold lets the input back up
    always @(negedge i_clk) begin
        if (long_hold) begin
            if (held_cycles < HOLD_CYCLES) begin
                m_axis_tready <= 1'b0;
                held_cycles++;
            end else begin
                long_hold = 1'b0;
                held_cycles = 0;
                m_axis_tready <= 1'b1;
            end
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_element(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_char(s_axis_tdata);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0)
            @(negedge i_clk);
        // dropped codes leave nothing to wait for, so also wait out a settling period
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == REG_UNIT_TICKS)
            sb.unit_ticks = val[15:0];
        @(negedge i_clk);
        // read back the live register
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= REG_UNIT_TICKS;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'd0, sb.unit_ticks})
            sb.mismatch("unit_ticks readback", {16'd0, sb.unit_ticks}, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'(($urandom_range(1) ? CH_UC_A : CH_LC_A) + $urandom_range(25));
        else if (r < 85)
            return CH_SPACE;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        logic [7:0] directed[22];
        logic [15:0] unit_val;
        int p;
        int n;

        sb = new();
        // edges of the letter ranges, codes that must be dropped, and
        // the shortest, longest, all-dot and all-dash letters
        directed = '{"A", "Z", "a", "z", " ", 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B,
                     8'h7F, 8'h80, "E", "T", "H", "O", "Q", "J", "Y", "b", "x"};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i])
            send_char(directed[i]);
        wait_idle();
        // nothing lives at this address; the unit length must not move
        reg_write(REG_UNUSED, 32'h0000_0BAD);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                1: unit_val = 16'hFFFF;
                2: unit_val = 16'd1;
                3: unit_val = 16'd0;
                4: unit_val = 16'($urandom_range(2, 65534));
                default: unit_val = sb.unit_ticks;
            endcase
            if (p != 0)
                reg_write(REG_UNIT_TICKS, {16'($urandom_range(65535)), unit_val});
            case (p % 4)
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                3: begin send_idle_pct = 35; stall_pct = 35; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            if (p == 0)
                long_hold = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_char(pick_char());
        end
        wait_idle();

        $display("tb: %0d characters in, %0d elements checked", sb.chars_taken,
                 sb.elems_checked);
        $display("tb: unit lengths reset, 65535, 1, 0 and random;");
        $display("tb: four pacing modes and one long output hold");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/mce_pkg.sv
rtl/mce_seq.sv
rtl/mce_datapath.sv
rtl/morse_character_encoder.sv
sim/tb_top.sv
